[rtl/core/msk_pkg.sv]
// Shared constants, codes and control types for the keyed multi-stack block.
package msk_pkg;

  localparam int unsigned STACKS  = 8;
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned STK_W   = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned ADDR_W  = STK_W + POS_W;
  localparam int unsigned SLOTS   = STACKS * DEPTH;
  localparam int unsigned KEY_W   = 48;
  localparam int unsigned NSTK_W  = 4;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_STACKS_IN_USE  = 1'b0,
    REG_STACK_CAPACITY = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_STACK,
    S_READ,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic push;
    logic scan_init;
    logic next_stack;
    logic load_pos;
    logic rd_slot;
    logic dec_pos;
    logic rd_shift;
    logic wr_shift;
    logic remove_commit;
    logic not_found;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic stack_done;
    logic stack_empty;
    logic match;
    logic pos_zero;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/msk_req_if.sv]
// Request channel interface: valid/ready handshake with the entry payload.
interface msk_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  stack_number;
  logic [31:0] container_number;
  logic [15:0] company_code;

  modport source (output valid, opcode, stack_number, container_number, company_code,
                  input ready);
  modport sink   (input valid, opcode, stack_number, container_number, company_code,
                  output ready);
endinterface

[rtl/core/msk_rsp_if.sv]
// Response channel interface: valid/ready handshake with the status payload.
interface msk_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] stack_hit;
  logic [4:0] fill_after;

  modport source (output valid, status, stack_hit, fill_after, input ready);
  modport sink   (input valid, status, stack_hit, fill_after, output ready);
endinterface

[rtl/core/msk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module msk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/msk_ctrl.sv]
// Sequencer for push, search and shift-down steps of the keyed stacks.
module msk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  msk_pkg::sts_t sts_i,
  output logic          req_ready_o,
  output msk_pkg::cmd_t cmd_o
);

  msk_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msk_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      msk_pkg::S_IDLE: begin
        if (req_valid_i) state_d = msk_pkg::S_EXEC;
      end
      msk_pkg::S_EXEC: begin
        state_d = sts_i.is_remove ? msk_pkg::S_STACK : msk_pkg::S_EMIT;
      end
      msk_pkg::S_STACK: begin
        if (sts_i.stack_done) begin
          state_d = msk_pkg::S_EMIT;
        end else if (!sts_i.stack_empty) begin
          state_d = msk_pkg::S_READ;
        end
      end
      msk_pkg::S_READ: begin
        state_d = msk_pkg::S_CMP;
      end
      msk_pkg::S_CMP: begin
        if (sts_i.match) begin
          state_d = msk_pkg::S_SHIFT_RD;
        end else if (sts_i.pos_zero) begin
          state_d = msk_pkg::S_STACK;
        end else begin
          state_d = msk_pkg::S_READ;
        end
      end
      msk_pkg::S_SHIFT_RD: begin
        state_d = sts_i.shift_more ? msk_pkg::S_SHIFT_WR : msk_pkg::S_EMIT;
      end
      msk_pkg::S_SHIFT_WR: begin
        state_d = msk_pkg::S_SHIFT_RD;
      end
      msk_pkg::S_EMIT: begin
        if (sts_i.out_free) state_d = msk_pkg::S_IDLE;
      end
      default: state_d = msk_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      msk_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      msk_pkg::S_EXEC: begin
        cmd_o.push      = !sts_i.is_remove;
        cmd_o.scan_init = sts_i.is_remove;
      end
      msk_pkg::S_STACK: begin
        cmd_o.not_found  = sts_i.stack_done;
        cmd_o.next_stack = !sts_i.stack_done && sts_i.stack_empty;
        cmd_o.load_pos   = !sts_i.stack_done && !sts_i.stack_empty;
      end
      msk_pkg::S_READ: begin
        cmd_o.rd_slot = 1'b1;
      end
      msk_pkg::S_CMP: begin
        cmd_o.next_stack = !sts_i.match && sts_i.pos_zero;
        cmd_o.dec_pos    = !sts_i.match && !sts_i.pos_zero;
      end
      msk_pkg::S_SHIFT_RD: begin
        cmd_o.rd_shift      = sts_i.shift_more;
        cmd_o.remove_commit = !sts_i.shift_more;
      end
      msk_pkg::S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
      end
      msk_pkg::S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/core/msk_dp.sv]
// Datapath: request latch, fill counters, slot RAM, scan pointers, result registers.
module msk_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  msk_pkg::cmd_t                cmd_i,
  output msk_pkg::sts_t                sts_o,
  input  logic [msk_pkg::NSTK_W-1:0]   stacks_in_use_i,
  input  logic [msk_pkg::FILL_W-1:0]   stack_capacity_i,
  input  logic                         opcode_i,
  input  logic [3:0]                   stack_number_i,
  input  logic [31:0]                  container_number_i,
  input  logic [15:0]                  company_code_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [2:0]                   status_o,
  output logic [2:0]                   stack_hit_o,
  output logic [4:0]                   fill_after_o
);

  logic                         op_q;
  logic [3:0]                   sn_q;
  logic [msk_pkg::KEY_W-1:0]    key_q;
  logic [msk_pkg::NSTK_W-1:0]   s_q;
  logic [msk_pkg::POS_W-1:0]    pos_q;
  logic [msk_pkg::FILL_W-1:0]   fill_q [msk_pkg::STACKS];

  msk_pkg::status_e             res_status_q;
  logic [msk_pkg::STK_W-1:0]    res_hit_q;
  logic [msk_pkg::FILL_W-1:0]   res_fill_q;

  logic                         out_valid_q;
  msk_pkg::status_e             out_status_q;
  logic [msk_pkg::STK_W-1:0]    out_hit_q;
  logic [msk_pkg::FILL_W-1:0]   out_fill_q;

  logic [msk_pkg::NSTK_W-1:0]   m_eff;
  logic [msk_pkg::FILL_W-1:0]   cap_eff;
  logic [msk_pkg::STK_W-1:0]    push_idx;
  logic [msk_pkg::STK_W-1:0]    scan_idx;
  logic [msk_pkg::STK_W-1:0]    fill_idx;
  logic [msk_pkg::FILL_W-1:0]   fill_cur;
  logic [msk_pkg::FILL_W-1:0]   fill_inc;
  logic [msk_pkg::FILL_W-1:0]   fill_dec;
  logic [msk_pkg::POS_W-1:0]    pos_inc;
  logic                         push_invalid;
  logic                         push_full;
  logic                         push_ok;

  logic                         ram_we;
  logic [msk_pkg::ADDR_W-1:0]   ram_waddr;
  logic [msk_pkg::KEY_W-1:0]    ram_wdata;
  logic                         ram_re;
  logic [msk_pkg::ADDR_W-1:0]   ram_raddr;
  logic [msk_pkg::KEY_W-1:0]    ram_rdata;

  assign m_eff   = (stacks_in_use_i > msk_pkg::NSTK_W'(msk_pkg::STACKS)) ?
                   msk_pkg::NSTK_W'(msk_pkg::STACKS) : stacks_in_use_i;
  assign cap_eff = (stack_capacity_i > msk_pkg::FILL_W'(msk_pkg::DEPTH)) ?
                   msk_pkg::FILL_W'(msk_pkg::DEPTH) : stack_capacity_i;

  assign push_idx = msk_pkg::STK_W'(sn_q - 4'd1);
  assign scan_idx = s_q[msk_pkg::STK_W-1:0];
  assign fill_idx = (op_q == msk_pkg::OP_REMOVE) ? scan_idx : push_idx;
  assign fill_cur = fill_q[fill_idx];
  assign fill_inc = fill_cur + msk_pkg::FILL_W'(1);
  assign fill_dec = fill_cur - msk_pkg::FILL_W'(1);
  assign pos_inc  = pos_q + msk_pkg::POS_W'(1);

  assign push_invalid = (sn_q == 4'd0) || (sn_q > m_eff);
  assign push_full    = fill_cur >= cap_eff;
  assign push_ok      = !push_invalid && !push_full;

  assign sts_o.is_remove   = (op_q == msk_pkg::OP_REMOVE);
  assign sts_o.stack_done  = s_q >= m_eff;
  assign sts_o.stack_empty = fill_cur == '0;
  assign sts_o.match       = ram_rdata == key_q;
  assign sts_o.pos_zero    = pos_q == '0;
  assign sts_o.shift_more  = ({1'b0, pos_q} + msk_pkg::FILL_W'(1)) < fill_cur;
  assign sts_o.out_free    = !out_valid_q || rsp_ready_i;

  // Slot RAM: one write (push or shift-down), one read (scan or shift source)
  assign ram_we    = (cmd_i.push && push_ok) || cmd_i.wr_shift;
  assign ram_waddr = cmd_i.wr_shift ? {scan_idx, pos_q}
                                    : {push_idx, fill_cur[msk_pkg::POS_W-1:0]};
  assign ram_wdata = cmd_i.wr_shift ? ram_rdata : key_q;
  assign ram_re    = cmd_i.rd_slot || cmd_i.rd_shift;
  assign ram_raddr = cmd_i.rd_shift ? {scan_idx, pos_inc} : {scan_idx, pos_q};

  msk_ram #(
    .Width (msk_pkg::KEY_W),
    .Depth (msk_pkg::SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state: fills, scan pointers, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msk_pkg::STACKS; i++) begin
        fill_q[i] <= '0;
      end
      s_q         <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push && push_ok) begin
        fill_q[push_idx] <= fill_inc;
      end
      if (cmd_i.remove_commit) begin
        fill_q[scan_idx] <= fill_dec;
      end
      if (cmd_i.scan_init) begin
        s_q <= '0;
      end else if (cmd_i.next_stack) begin
        s_q <= s_q + msk_pkg::NSTK_W'(1);
      end
      if (cmd_i.load_pos) begin
        pos_q <= msk_pkg::POS_W'(fill_dec);
      end else if (cmd_i.dec_pos) begin
        pos_q <= pos_q - msk_pkg::POS_W'(1);
      end else if (cmd_i.wr_shift) begin
        pos_q <= pos_inc;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: request latch, result, output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      sn_q  <= stack_number_i;
      key_q <= {company_code_i, container_number_i};
    end
    if (cmd_i.push) begin
      if (push_invalid) begin
        res_status_q <= msk_pkg::ST_INVALID;
        res_hit_q    <= '0;
        res_fill_q   <= '0;
      end else if (push_full) begin
        res_status_q <= msk_pkg::ST_FULL;
        res_hit_q    <= '0;
        res_fill_q   <= fill_cur;
      end else begin
        res_status_q <= msk_pkg::ST_PUSHED;
        res_hit_q    <= push_idx;
        res_fill_q   <= fill_inc;
      end
    end else if (cmd_i.remove_commit) begin
      res_status_q <= msk_pkg::ST_REMOVED;
      res_hit_q    <= scan_idx;
      res_fill_q   <= fill_dec;
    end else if (cmd_i.not_found) begin
      res_status_q <= msk_pkg::ST_NOTFOUND;
      res_hit_q    <= '0;
      res_fill_q   <= '0;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
      out_fill_q   <= res_fill_q;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign stack_hit_o  = out_hit_q;
  assign fill_after_o = out_fill_q;

endmodule

[rtl/core/multi_stack_keyed_remove.sv]
// Top level of the keyed multi-stack block: config registers, sequencer, datapath.
//
// Usage: requests arrive on req_i (valid/ready). A push (opcode 0) places the
// 48-bit key {company_code, container_number} on the 1-based stack_number; a
// remove (opcode 1) searches stacks 0 up to stacks_in_use-1, each top to
// bottom, deletes the first match and slides the entries above it down.
// Each request yields exactly one response on rsp_o: status, stack_hit and
// fill_after.
// Timing: the block takes one request at a time. A push passes through the
// execute and emit states after acceptance. A remove spends a start-up step
// on each stack, a read step and a compare step per slot compared (registered
// read of the single slot RAM port, then the compare), and a read step and a
// write step per entry moved down. The slot RAM's single read port sets this.
// The response sits in an output register, so req_i is ready again as soon
// as a result is handed over, even while rsp_o is stalled; a finished result
// waits for the output register to free up before the next one is loaded.
// Reset empties every stack (fill counters clear at once; slot contents are
// left as they are) and sets stacks_in_use to 8 and stack_capacity to 16.
// Configuration: APB, address 0 stacks_in_use, address 4 stack_capacity.
module multi_stack_keyed_remove (
  input  logic              clk_i,
  input  logic              rst_ni,
  msk_req_if.sink           req_i,
  msk_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [msk_pkg::NSTK_W-1:0] stacks_in_use_q;
  logic [msk_pkg::FILL_W-1:0] stack_capacity_q;
  msk_pkg::reg_idx_e          reg_sel;
  logic                       cfg_wr;

  msk_pkg::cmd_t cmd;
  msk_pkg::sts_t sts;

  // Decode by word index; byte lanes are ignored
  assign reg_sel = msk_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stacks_in_use_q  <= msk_pkg::NSTK_W'(8);
      stack_capacity_q <= msk_pkg::FILL_W'(16);
    end else if (cfg_wr) begin
      case (reg_sel)
        msk_pkg::REG_STACKS_IN_USE:  stacks_in_use_q  <= pwdata[msk_pkg::NSTK_W-1:0];
        msk_pkg::REG_STACK_CAPACITY: stack_capacity_q <= pwdata[msk_pkg::FILL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      msk_pkg::REG_STACKS_IN_USE:  prdata = 32'(stacks_in_use_q);
      msk_pkg::REG_STACK_CAPACITY: prdata = 32'(stack_capacity_q);
      default:                     prdata = '0;
    endcase
  end

  msk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  msk_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .stacks_in_use_i    (stacks_in_use_q),
    .stack_capacity_i   (stack_capacity_q),
    .opcode_i           (req_i.opcode),
    .stack_number_i     (req_i.stack_number),
    .container_number_i (req_i.container_number),
    .company_code_i     (req_i.company_code),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .status_o           (rsp_o.status),
    .stack_hit_o        (rsp_o.stack_hit),
    .fill_after_o       (rsp_o.fill_after)
  );

  // One request in flight: the cycle after acceptance the block is busy
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while previous one still busy");

  // A successful push always leaves a non-empty stack
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == msk_pkg::ST_PUSHED) |-> (rsp_o.fill_after != 5'd0))
    else $error("push reported an empty stack");

  // A removal never leaves a stack at full depth
  a_remove_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == msk_pkg::ST_REMOVED)
    |-> (rsp_o.fill_after < 5'(msk_pkg::DEPTH)))
    else $error("remove reported fill at full depth");

  // Invalid and not-found results carry no stack and no fill
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && ((rsp_o.status == msk_pkg::ST_INVALID) ||
                    (rsp_o.status == msk_pkg::ST_NOTFOUND))
    |-> (rsp_o.stack_hit == 3'd0) && (rsp_o.fill_after == 5'd0))
    else $error("miss result carries stack or fill");

endmodule

[tb/multi_stack_keyed_remove_tb.sv]
// Self-checking testbench for the keyed multi-stack block: directed and random requests.
module multi_stack_keyed_remove_tb;
  import msk_pkg::*;

  // Overall time limit, with ample room for worst-case removes plus idling.
  localparam int unsigned LIMIT_TIME    = 20_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned PHASES        = 9;

  typedef struct packed {
    opcode_e     op;
    logic [3:0]  stack_no;
    logic [31:0] number;
    logic [15:0] code;
  } request_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] hit;
    logic [4:0] fill;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  msk_req_if req_if ();
  msk_rsp_if rsp_if ();

  multi_stack_keyed_remove u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the stacks and the two registers, kept in step with the block.
  logic [KEY_W-1:0]  key_mem  [SLOTS];
  logic [FILL_W-1:0] fill_cnt [STACKS];
  logic [3:0]        cfg_stacks;
  logic [4:0]        cfg_capacity;

  request_t         request_q [$];  // requests waiting to be driven
  outcome_t         outcome_q [$];  // predicted responses, oldest first
  logic [KEY_W-1:0] live_keys [$];  // keys pushed so far, used to aim removes

  int unsigned mismatches = 0;
  int unsigned idle_pct   = 0;      // percent chance that an idle burst starts
  int unsigned req_gap    = 0;
  int unsigned rsp_stall  = 0;
  bit          req_fired  = 1'b0;   // request handed over at the last rising edge

  // Register settings of the random phases: extremes, out-of-range values that
  // saturate, zero stacks and zero capacity. The last phase runs without idling.
  int unsigned phase_stacks [PHASES] = '{8, 1, 3, 15, 2, 0, 8, 5, 8};
  int unsigned phase_cap    [PHASES] = '{16, 16, 5, 31, 1, 3, 0, 9, 16};
  int unsigned phase_items  [PHASES] = '{240, 200, 200, 220, 150, 30, 30, 200, 280};
  int unsigned phase_idle   [PHASES] = '{25, 50, 15, 30, 40, 20, 20, 10, 0};

  // Apply one request to the shadow stacks and return the response it must give.
  function automatic outcome_t apply_request(request_t rq);
    outcome_t         res;
    int unsigned      live;
    int unsigned      cap;
    int unsigned      f;
    int unsigned      base;
    int unsigned      s;
    logic [KEY_W-1:0] key;
    live       = (cfg_stacks > STACKS) ? STACKS : cfg_stacks;
    cap        = (cfg_capacity > DEPTH) ? DEPTH : cfg_capacity;
    key        = {rq.code, rq.number};
    res.status = ST_NOTFOUND;
    res.hit    = '0;
    res.fill   = '0;
    if (rq.op == OP_PUSH) begin
      if (rq.stack_no < 1 || rq.stack_no > live) begin
        res.status = ST_INVALID;
        return res;
      end
      s = rq.stack_no - 1;
      f = fill_cnt[s];
      if (f >= cap) begin
        // full, or capacity lowered below the fill: report the fill unchanged
        res.status = ST_FULL;
        res.fill   = FILL_W'(f);
        return res;
      end
      key_mem[s * DEPTH + f] = key;
      fill_cnt[s]            = FILL_W'(f + 1);
      res.status             = ST_PUSHED;
      res.hit                = 3'(s);
      res.fill               = FILL_W'(f + 1);
      return res;
    end
    // Search stacks in index order, each from the top down; slide entries above
    // the hit down one slot so their order is kept.
    for (s = 0; s < live; s++) begin
      f    = fill_cnt[s];
      base = s * DEPTH;
      for (int k = f; k > 0; k--) begin
        if (key_mem[base + k - 1] == key) begin
          for (int j = k - 1; j + 1 < f; j++) key_mem[base + j] = key_mem[base + j + 1];
          fill_cnt[s] = FILL_W'(f - 1);
          res.status  = ST_REMOVED;
          res.hit     = 3'(s);
          res.fill    = FILL_W'(f - 1);
          return res;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [31:0] num;
    logic [15:0] code;
    case ($urandom_range(3))
      0: begin
        // small space: duplicates and near misses on either field
        num  = $urandom_range(7);
        code = 16'($urandom_range(3));
      end
      1: begin
        num  = $urandom();
        code = 16'($urandom());
      end
      2: begin
        num  = $urandom();
        code = 16'($urandom_range(3));
      end
      default: begin
        num  = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        code = $urandom_range(1) ? 16'hFFFF : 16'h0;
      end
    endcase
    return {code, num};
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic queue_one(opcode_e op, logic [3:0] stack_no, logic [31:0] number,
                           logic [15:0] code);
    request_t rq;
    rq.op       = op;
    rq.stack_no = stack_no;
    rq.number   = number;
    rq.code     = code;
    request_q.push_back(rq);
  endtask

  // Queue random requests shaped by the current settings: mostly pushes onto
  // live stacks and removes of earlier keys, the rest invalid stacks and misses.
  task automatic queue_random(int unsigned count);
    request_t    rq;
    int unsigned live;
    int unsigned room;
    int unsigned idx;
    bit          do_push;
    live = (cfg_stacks > STACKS) ? STACKS : cfg_stacks;
    room = live * ((cfg_capacity > DEPTH) ? DEPTH : cfg_capacity);
    repeat (count) begin
      {rq.code, rq.number} = random_key();
      rq.stack_no          = 4'($urandom_range(15));
      // hover around the total room so stacks run full now and then
      if (live_keys.size() < room + 2) do_push = ($urandom_range(99) < 65);
      else do_push = ($urandom_range(99) < 30);
      if (do_push) begin
        rq.op = OP_PUSH;
        if (live != 0 && $urandom_range(99) < 85) rq.stack_no = 4'($urandom_range(live, 1));
        live_keys.push_back({rq.code, rq.number});
        if (live_keys.size() > 256) live_keys.delete(0);
      end else begin
        rq.op = OP_REMOVE;
        if (live_keys.size() != 0 && $urandom_range(99) < 80) begin
          idx                  = $urandom_range(live_keys.size() - 1);
          {rq.code, rq.number} = live_keys[idx];
          live_keys.delete(idx);
        end else if (live_keys.size() != 0 && $urandom_range(1) == 1) begin
          // near miss: same number, different code
          {rq.code, rq.number} = live_keys[$urandom_range(live_keys.size() - 1)];
          rq.code              = rq.code ^ 16'($urandom_range(65535, 1));
        end
      end
      request_q.push_back(rq);
    end
  endtask

  // Hold until every queued request is taken and every response has come back.
  task automatic wait_drained();
    while (request_q.size() != 0 || req_if.valid || outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write a register over APB, read it back, and update the shadow copy.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_STACKS_IN_USE) ? 32'h0000_000F : 32'h0000_001F;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value & mask;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & mask))
      note_mismatch($sformatf("register %s read back %h, expected %h",
                              idx.name(), prdata, value & mask));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (idx == REG_STACKS_IN_USE) cfg_stacks = value[3:0];
    else cfg_capacity = value[4:0];
  endtask

  // Monitor: predict on each accepted request, check each accepted response.
  always @(posedge clk_i) begin
    request_t seen;
    outcome_t got;
    outcome_t want;
    req_fired = rst_ni && req_if.valid && req_if.ready;
    if (req_fired) begin
      seen.op       = opcode_e'(req_if.opcode);
      seen.stack_no = req_if.stack_number;
      seen.number   = req_if.container_number;
      seen.code     = req_if.company_code;
      outcome_q.push_back(apply_request(seen));
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status = status_e'(rsp_if.status);
      got.hit    = rsp_if.stack_hit;
      got.fill   = rsp_if.fill_after;
      if (outcome_q.size() == 0) begin
        note_mismatch($sformatf("response with no request pending: status %0d hit %0d fill %0d",
                                got.status, got.hit, got.fill));
      end else begin
        want = outcome_q.pop_front();
        if (got.status !== want.status || got.hit !== want.hit || got.fill !== want.fill)
          note_mismatch($sformatf("expected status %0d hit %0d fill %0d, got %0d %0d %0d",
                                  want.status, want.hit, want.fill,
                                  got.status, got.hit, got.fill));
      end
    end
  end

  // Driver: present the next request once the previous one was taken, with
  // random bursts of idle cycles between requests.
  always @(negedge clk_i) begin
    request_t nxt;
    logic     drive_valid;
    if (rst_ni && (!req_if.valid || req_fired)) begin
      drive_valid = 1'b0;
      if (req_gap != 0) begin
        req_gap--;
      end else if (request_q.size() != 0) begin
        nxt                     = request_q.pop_front();
        req_if.opcode           <= nxt.op;
        req_if.stack_number     <= nxt.stack_no;
        req_if.container_number <= nxt.number;
        req_if.company_code     <= nxt.code;
        drive_valid             = 1'b1;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) req_gap = $urandom_range(4, 1);
      end
      req_if.valid <= drive_valid;
    end
  end

  // Response sink: stall in random bursts.
  always @(negedge clk_i) begin
    if (rsp_stall != 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      rsp_stall = $urandom_range(3);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    req_if.valid            = 1'b0;
    req_if.opcode           = OP_PUSH;
    req_if.stack_number     = '0;
    req_if.container_number = '0;
    req_if.company_code     = '0;
    rsp_if.ready            = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    cfg_stacks              = 4'd8;
    cfg_capacity            = 5'd16;
    foreach (fill_cnt[i]) fill_cnt[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni   = 1'b1;
    idle_pct = 20;

    // Directed: invalid stack numbers, key extremes, duplicates, a near miss,
    // removal from the middle of a stack, search order across stacks.
    queue_one(OP_PUSH, 4'd0, 32'd1, 16'd1);
    queue_one(OP_PUSH, 4'd9, 32'd1, 16'd1);
    queue_one(OP_PUSH, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
    queue_one(OP_PUSH, 4'd1, 32'h0, 16'h0);
    queue_one(OP_PUSH, 4'd1, 32'hFFFF_FFFF, 16'hFFFF);
    queue_one(OP_PUSH, 4'd1, 32'd5, 16'd7);
    queue_one(OP_PUSH, 4'd1, 32'h0, 16'h0);
    queue_one(OP_PUSH, 4'd8, 32'd5, 16'd7);
    queue_one(OP_REMOVE, 4'd3, 32'd5, 16'd0);
    queue_one(OP_REMOVE, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
    queue_one(OP_REMOVE, 4'd15, 32'd5, 16'd7);
    queue_one(OP_REMOVE, 4'd0, 32'd5, 16'd7);
    queue_one(OP_REMOVE, 4'd0, 32'd5, 16'd7);
    wait_drained();

    // No stacks in use: every push invalid, every remove a miss.
    write_reg(REG_STACKS_IN_USE, 32'd0);
    queue_one(OP_PUSH, 4'd1, 32'd2, 16'd2);
    queue_one(OP_REMOVE, 4'd0, 32'h0, 16'h0);
    wait_drained();

    // Stack count above the build saturates; small capacity fills at once.
    write_reg(REG_STACKS_IN_USE, 32'd15);
    write_reg(REG_STACK_CAPACITY, 32'd2);
    queue_one(OP_PUSH, 4'd8, 32'd1, 16'd1);
    queue_one(OP_PUSH, 4'd1, 32'd3, 16'd3);
    wait_drained();

    // Capacity lowered below the fill: pushes report full, removes still work.
    write_reg(REG_STACK_CAPACITY, 32'd1);
    queue_one(OP_PUSH, 4'd1, 32'd3, 16'd3);
    queue_one(OP_REMOVE, 4'd0, 32'h0, 16'h0);
    wait_drained();
    write_reg(REG_STACK_CAPACITY, 32'd0);
    queue_one(OP_PUSH, 4'd2, 32'd3, 16'd3);
    wait_drained();

    // Entries on stacks beyond the count are kept but not searched.
    write_reg(REG_STACKS_IN_USE, 32'd1);
    write_reg(REG_STACK_CAPACITY, 32'd16);
    queue_one(OP_REMOVE, 4'd0, 32'd1, 16'd1);
    queue_one(OP_PUSH, 4'd2, 32'd3, 16'd3);
    wait_drained();
    write_reg(REG_STACKS_IN_USE, 32'd8);
    queue_one(OP_REMOVE, 4'd0, 32'd1, 16'd1);
    queue_one(OP_REMOVE, 4'd0, 32'h0, 16'h0);
    wait_drained();

    // Random phases; in the third one the sender pauses halfway until every
    // response is back.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_STACKS_IN_USE, phase_stacks[p]);
      write_reg(REG_STACK_CAPACITY, phase_cap[p]);
      idle_pct = phase_idle[p];
      queue_random(phase_items[p] / 2);
      if (p == 2) wait_drained();
      queue_random(phase_items[p] - phase_items[p] / 2);
      wait_drained();
    end

    // Let any stray response show up before judging the run.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(LIMIT_TIME);
    $display("Mismatches found");
    $finish;
  end

endmodule
